// ===== rtl/checksummed_packet_framer_macros.svh =====
// Assertion macros used by the checksummed packet framer checker.
`ifndef CHECKSUMMED_PACKET_FRAMER_MACROS_SVH
`define CHECKSUMMED_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst is high.
`define CPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer check failed");

// Next-cycle implication, sampled on clk and quiet while rst is high.
`define CPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

// ===== rtl/cpf_pkg.sv =====
// Shared constants and types for the checksummed packet framer.
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

  localparam logic [7:0] SYNC_A  = 8'hAA;
  localparam logic [7:0] SYNC_B  = 8'h55;
  localparam logic [7:0] TAIL_CR = 8'h0D;
  localparam logic [7:0] TAIL_LF = 8'h0A;

  // Position of the byte being sent within one item's output run.
  typedef enum logic [3:0] {
    STEP_SYNC_A,
    STEP_SYNC_B,
    STEP_CMD,
    STEP_LEN_LO,
    STEP_LEN_HI,
    STEP_DATA,
    STEP_SUM,
    STEP_CR,
    STEP_LF
  } step_t;

  // Everything the emitter needs to send the bytes caused by one item.
  typedef struct packed {
    logic       emit;    // the item produces at least one byte
    logic       start;   // header bytes come first
    logic [7:0] cmd;
    logic [7:0] len_lo;
    logic [7:0] len_hi;
    logic [7:0] data;
    logic       pay;     // a payload byte is sent
    logic       tail;    // checksum, CR and LF close the frame
    logic [7:0] sum;     // checksum byte sent in the tail
  } plan_t;

endpackage

`default_nettype wire

// ===== rtl/cpf_frame_ctl.sv =====
// Frame state tracking: running checksum, remaining count and open-frame flag.
`timescale 1ns / 1ps
`default_nettype none

module cpf_frame_ctl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic           start_req,
  input  wire logic [7:0]     cmd,
  input  wire logic [15:0]    length,
  input  wire logic [7:0]     data_byte,
  output cpf_pkg::plan_t      plan
);

  logic [7:0]  running_sum;
  logic [15:0] bytes_left;
  logic        in_packet;

  logic [7:0]  hdr_sum;
  logic [7:0]  base_sum;
  logic [7:0]  pay_sum;
  logic [15:0] left_cur;
  logic [15:0] left_after;

  // Work out the bytes this beat causes and the checksum they leave behind.
  always_comb begin
    hdr_sum = cpf_pkg::SYNC_A + cpf_pkg::SYNC_B + cmd + length[7:0] + length[15:8];
    if (start_req) begin
      plan.emit = 1'b1;
      plan.pay  = (length != 16'd0);
      base_sum  = hdr_sum;
      left_cur  = length;
    end else begin
      plan.emit = in_packet;
      plan.pay  = in_packet;
      base_sum  = running_sum;
      left_cur  = bytes_left;
    end
    pay_sum    = base_sum + data_byte;
    left_after = left_cur - 16'd1;
    plan.start  = start_req;
    plan.cmd    = cmd;
    plan.len_lo = length[7:0];
    plan.len_hi = length[15:8];
    plan.data   = data_byte;
    plan.tail   = !plan.pay || (left_after == 16'd0);
    plan.sum    = plan.pay ? pay_sum : base_sum;
  end

  // Frame state advances once per accepted beat that produces bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'd0;
      bytes_left  <= 16'd0;
      in_packet   <= 1'b0;
    end else if (accept && plan.emit) begin
      if (plan.tail) begin
        running_sum <= 8'd0;
        bytes_left  <= 16'd0;
        in_packet   <= 1'b0;
      end else begin
        running_sum <= pay_sum;
        bytes_left  <= left_after;
        in_packet   <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cpf_emitter.sv =====
// Byte sequencer: holds one item's plan and sends its bytes through an output register.
`timescale 1ns / 1ps
`default_nettype none

module cpf_emitter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire cpf_pkg::plan_t plan,
  output logic                ready,
  output logic                byte_valid,
  input  wire logic           byte_ready,
  output logic [7:0]          out_byte,
  output logic                frame_end
);

  logic            wvalid;
  cpf_pkg::plan_t  wplan;
  cpf_pkg::step_t  step;
  cpf_pkg::step_t  step_next;
  logic [7:0]      cur_byte;
  logic            last;
  logic            out_load;

  assign out_load = !byte_valid || byte_ready;
  assign ready    = !wvalid || (out_load && last);

  // Select the current byte and the step that follows it.
  always_comb begin
    cur_byte  = wplan.data;
    step_next = cpf_pkg::STEP_LF;
    case (step)
      cpf_pkg::STEP_SYNC_A: begin
        cur_byte  = cpf_pkg::SYNC_A;
        step_next = cpf_pkg::STEP_SYNC_B;
      end
      cpf_pkg::STEP_SYNC_B: begin
        cur_byte  = cpf_pkg::SYNC_B;
        step_next = cpf_pkg::STEP_CMD;
      end
      cpf_pkg::STEP_CMD: begin
        cur_byte  = wplan.cmd;
        step_next = cpf_pkg::STEP_LEN_LO;
      end
      cpf_pkg::STEP_LEN_LO: begin
        cur_byte  = wplan.len_lo;
        step_next = cpf_pkg::STEP_LEN_HI;
      end
      cpf_pkg::STEP_LEN_HI: begin
        cur_byte  = wplan.len_hi;
        step_next = wplan.pay ? cpf_pkg::STEP_DATA : cpf_pkg::STEP_SUM;
      end
      cpf_pkg::STEP_DATA: begin
        cur_byte  = wplan.data;
        step_next = cpf_pkg::STEP_SUM;
      end
      cpf_pkg::STEP_SUM: begin
        cur_byte  = wplan.sum;
        step_next = cpf_pkg::STEP_CR;
      end
      cpf_pkg::STEP_CR: begin
        cur_byte  = cpf_pkg::TAIL_CR;
        step_next = cpf_pkg::STEP_LF;
      end
      cpf_pkg::STEP_LF: begin
        cur_byte  = cpf_pkg::TAIL_LF;
        step_next = cpf_pkg::STEP_LF;
      end
      default: begin
        cur_byte  = wplan.data;
        step_next = cpf_pkg::STEP_LF;
      end
    endcase
    last = (step == cpf_pkg::STEP_LF) || ((step == cpf_pkg::STEP_DATA) && !wplan.tail);
  end

  // Work register: load a new item or step through the current one.
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= 1'b0;
      step   <= cpf_pkg::STEP_SYNC_A;
    end else if (wvalid && out_load && !last) begin
      step <= step_next;
    end else if (take) begin
      wvalid <= 1'b1;
      wplan  <= plan;
      step   <= plan.start ? cpf_pkg::STEP_SYNC_A : cpf_pkg::STEP_DATA;
    end else if (wvalid && out_load) begin
      wvalid <= 1'b0;
    end
  end

  // Output register: holds a beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (out_load) begin
      byte_valid <= wvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && wvalid) begin
      out_byte  <= cur_byte;
      frame_end <= (step == cpf_pkg::STEP_LF);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/checksummed_packet_framer.sv =====
// Top level of the checksummed packet framer.
//
//   Channel  Handshake                Payload
//   -------  -----------------------  -------------------------------------
//   item     item_valid / item_ready  start_req, cmd, length, data_byte
//   byte     byte_valid / byte_ready  out_byte, frame_end
//
// A payload beat sends one byte, so payload streams at one beat per cycle unless the
// byte channel stalls. A start beat sends 6 to 9 bytes and the last payload beat 4,
// one per cycle from the work register unless stalled; the next item is taken in the
// cycle its last byte moves to the output register. Bytes reach it via the work register.
// Synchronous reset clears the frame state and both valid flags.
// A stalled byte channel holds the output register and back-pressures item.
`timescale 1ns / 1ps
`default_nettype none

module checksummed_packet_framer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic        start_req,
  input  wire logic [7:0]  cmd,
  input  wire logic [15:0] length,
  input  wire logic [7:0]  data_byte,
  output logic             byte_valid,
  input  wire logic        byte_ready,
  output logic [7:0]       out_byte,
  output logic             frame_end
);

  cpf_pkg::plan_t plan;
  logic           accept;

  assign accept = item_valid && item_ready;

  // Frame state and per-item plan.
  cpf_frame_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .start_req (start_req),
    .cmd       (cmd),
    .length    (length),
    .data_byte (data_byte),
    .plan      (plan)
  );

  // Byte sequencing and output register.
  cpf_emitter u_emit (
    .clk        (clk),
    .rst        (rst),
    .take       (accept && plan.emit),
    .plan       (plan),
    .ready      (item_ready),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .out_byte   (out_byte),
    .frame_end  (frame_end)
  );

endmodule

`default_nettype wire

// ===== rtl/cpf_checker.sv =====
// Port-level checks for the checksummed packet framer and their bind.
`timescale 1ns / 1ps
`default_nettype none
`include "checksummed_packet_framer_macros.svh"

module cpf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        start_req,
  input wire logic        byte_valid,
  input wire logic        byte_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        frame_end
);

  // A stalled output beat keeps its payload.
  `CPF_ASSERT_NEXT(a_byte_hold, byte_valid && !byte_ready, byte_valid && $stable(out_byte) && $stable(frame_end))

  // The frame end marker only rides on the line feed byte.
  `CPF_ASSERT_NOW(a_end_is_lf, byte_valid && frame_end, out_byte == cpf_pkg::TAIL_LF)

  // An accepted start beat is always followed by a valid byte on the output register.
  `CPF_ASSERT_NOW(a_start_emits, item_valid && item_ready && start_req, ##2 byte_valid)

endmodule

bind checksummed_packet_framer cpf_checker u_chk (.*);

`default_nettype wire
